@@ sv/fpr_pkg.sv @@
`default_nettype none

package fpr_pkg;

    localparam logic [7:0] MARKER_RESET = 8'h99;
    localparam logic [7:0] MIN_LENGTH   = 8'd4;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [0:0] REG_START_MARKER = 1'b0;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_LEN  = 3'd1,
        PH_PAY  = 3'd2,
        PH_CK1  = 3'd3,
        PH_CK2  = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        ROLE_DISCARD = 3'd0,
        ROLE_MARKER  = 3'd1,
        ROLE_LENGTH  = 3'd2,
        ROLE_PAYLOAD = 3'd3,
        ROLE_CHECK1  = 3'd4,
        ROLE_CHECK2  = 3'd5
    } t_role;

    typedef enum logic [1:0] {
        ST_NONE   = 2'd0,
        ST_OK     = 2'd1,
        ST_CKERR  = 2'd2,
        ST_BADLEN = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] out_byte;
        t_role      byte_role;
        logic [7:0] frame_position;
        logic       frame_done;
        t_status    frame_status;
    } t_result;

endpackage

`default_nettype wire

@@ sv/framed_packet_receiver_core.sv @@
// Channel  | Direction | Handshake                     | Payload
// rx       | in        | i_rx_valid / o_rx_stall       | i_rx_byte
// out      | out       | o_out_valid / i_out_stall     | o_out_byte, o_byte_role,
//          |           |                               | o_frame_position, o_frame_done,
//          |           |                               | o_frame_status
// config   | in        | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// One byte is accepted per cycle while o_rx_stall is low; its result is registered
// in the output buffer. Parser state and running sums update once per accepted byte.
// A two-entry output buffer decouples the sides: o_rx_stall rises only once
// two results are waiting, so an output stall reaches the input once the skid fills.
// Reset is synchronous; the start marker returns to 0x99 and the parser to hunting.
`default_nettype none

module framed_packet_receiver_core
    import fpr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  i_rx_valid,
    output logic                       o_rx_stall,
    input  wire logic [7:0]            i_rx_byte,

    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [7:0]                 o_out_byte,
    output logic [2:0]                 o_byte_role,
    output logic [7:0]                 o_frame_position,
    output logic                       o_frame_done,
    output logic [1:0]                 o_frame_status,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    logic [7:0] r_marker;
    logic       w_cfg_wr;
    logic       w_push;
    logic       w_full;
    t_result    w_result;
    t_result    w_out;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marker <= MARKER_RESET;
        end else if (w_cfg_wr && (paddr[2] == REG_START_MARKER)) begin
            r_marker <= pwdata[7:0];
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_START_MARKER: prdata = {{(APB_DATA_W-8){1'b0}}, r_marker};
            default:          prdata = '0;
        endcase
    end

    assign o_rx_stall = w_full;
    assign w_push     = i_rx_valid && !w_full;

    fpr_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_byte   (i_rx_byte),
        .i_marker (r_marker),
        .o_result (w_result)
    );

    fpr_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_result),
        .o_full  (w_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (w_out)
    );

    assign o_out_byte       = w_out.out_byte;
    assign o_byte_role      = w_out.byte_role;
    assign o_frame_position = w_out.frame_position;
    assign o_frame_done     = w_out.frame_done;
    assign o_frame_status   = w_out.frame_status;

endmodule

`default_nettype wire

@@ sv/fpr_parser.sv @@
`default_nettype none

module fpr_parser
    import fpr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire logic [7:0] i_byte,
    input  wire logic [7:0] i_marker,
    output t_result         o_result
);

    t_phase     r_phase,   n_phase;
    logic [7:0] r_length,  n_length;
    logic [7:0] r_count,   n_count;
    logic [7:0] r_sum1,    n_sum1;
    logic [7:0] r_sum2,    n_sum2;
    logic       r_ck1_ok,  n_ck1_ok;

    logic [7:0] w_sum1_add;
    logic [7:0] w_count_inc;
    logic [8:0] w_pay_end;

    assign w_sum1_add  = r_sum1 + i_byte;
    assign w_count_inc = r_count + 8'd1;
    assign w_pay_end   = {1'b0, w_count_inc} + 9'd2;

    // Next state of the parser.
    always_comb begin
        n_phase  = r_phase;
        n_length = r_length;
        n_count  = r_count;
        n_sum1   = r_sum1;
        n_sum2   = r_sum2;
        n_ck1_ok = r_ck1_ok;
        unique case (r_phase)
            PH_LEN: begin
                n_length = i_byte;
                if (i_byte < MIN_LENGTH) begin
                    n_phase = PH_HUNT;
                    n_count = 8'd0;
                end else begin
                    n_sum1  = i_byte;
                    n_sum2  = i_byte;
                    n_count = 8'd2;
                    n_phase = (i_byte == MIN_LENGTH) ? PH_CK1 : PH_PAY;
                end
            end
            PH_PAY: begin
                n_sum1  = w_sum1_add;
                n_sum2  = r_sum2 + w_sum1_add;
                n_count = w_count_inc;
                if (w_pay_end >= {1'b0, r_length}) begin
                    n_phase = PH_CK1;
                end
            end
            PH_CK1: begin
                n_ck1_ok = (i_byte == r_sum1);
                n_count  = w_count_inc;
                n_phase  = PH_CK2;
            end
            PH_CK2: begin
                n_phase = PH_HUNT;
                n_count = 8'd0;
            end
            default: begin
                n_phase = PH_HUNT;
                if (i_byte == i_marker) begin
                    n_sum1   = 8'd0;
                    n_sum2   = 8'd0;
                    n_ck1_ok = 1'b0;
                    n_count  = 8'd1;
                    n_phase  = PH_LEN;
                end
            end
        endcase
    end

    // Classification of the byte in hand.
    always_comb begin
        o_result.out_byte       = i_byte;
        o_result.byte_role      = ROLE_DISCARD;
        o_result.frame_position = 8'd0;
        o_result.frame_done     = 1'b0;
        o_result.frame_status   = ST_NONE;
        unique case (r_phase)
            PH_LEN: begin
                o_result.byte_role      = ROLE_LENGTH;
                o_result.frame_position = 8'd1;
                if (i_byte < MIN_LENGTH) begin
                    o_result.frame_done   = 1'b1;
                    o_result.frame_status = ST_BADLEN;
                end
            end
            PH_PAY: begin
                o_result.byte_role      = ROLE_PAYLOAD;
                o_result.frame_position = r_count;
            end
            PH_CK1: begin
                o_result.byte_role      = ROLE_CHECK1;
                o_result.frame_position = r_count;
            end
            PH_CK2: begin
                o_result.byte_role      = ROLE_CHECK2;
                o_result.frame_position = r_count;
                o_result.frame_done     = 1'b1;
                o_result.frame_status   = (r_ck1_ok && (i_byte == r_sum2)) ? ST_OK : ST_CKERR;
            end
            default: begin
                if (i_byte == i_marker) begin
                    o_result.byte_role = ROLE_MARKER;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_length <= 8'd0;
            r_count  <= 8'd0;
            r_sum1   <= 8'd0;
            r_sum2   <= 8'd0;
            r_ck1_ok <= 1'b0;
        end else if (i_push) begin
            r_phase  <= n_phase;
            r_length <= n_length;
            r_count  <= n_count;
            r_sum1   <= n_sum1;
            r_sum2   <= n_sum2;
            r_ck1_ok <= n_ck1_ok;
        end
    end

    a_discard_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.byte_role == ROLE_DISCARD |-> !o_result.frame_done)
        else $error("discarded byte flagged as end of frame");

    a_done_resumes_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && o_result.frame_done |=> r_phase == PH_HUNT && r_count == 8'd0)
        else $error("parser did not return to hunting after a frame ended");

    a_marker_opens_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && o_result.byte_role == ROLE_MARKER |=> r_phase == PH_LEN)
        else $error("start marker did not open a frame");

endmodule

`default_nettype wire

@@ sv/fpr_out_buf.sv @@
`default_nettype none

module fpr_out_buf
    import fpr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_data,
    output logic         o_full,
    output logic         o_valid,
    input  wire logic    i_stall,
    output t_result      o_data
);

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    w_pop;

    assign w_pop   = r_main_valid && !i_stall;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;
    assign o_full  = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_main_valid || w_pop) begin
            r_main_valid <= r_skid_valid || i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_main_valid || w_pop) begin
            r_main <= r_skid_valid ? r_skid : i_data;
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid entry held without a head entry");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && r_skid_valid))
        else $error("transaction pushed into a full output buffer");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && w_pop |=> !r_skid_valid && r_main_valid && r_main == $past(r_skid))
        else $error("skid entry lost when the head was taken");

endmodule

`default_nettype wire
